// ===== hw/rtl/fvpd_pkg.sv =====
// shared widths, constants and register codes for the flywheel velocity drive
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fvpd_pkg;

    // moving-average window, a power of two so the floor average is a shift
    localparam int WINDOW_LOG2 = 3;
    localparam int WINDOW      = 1 << WINDOW_LOG2;

    localparam int SAMPLE_W = 13;
    localparam int SUM_W    = SAMPLE_W + WINDOW_LOG2;
    localparam int TARGET_W = 12;
    localparam int GAIN_W   = 8;
    localparam int THR_W    = 13;
    localparam int DRIVE_W  = 14;
    localparam int ERR_W    = 14;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int ACC_W    = 24;
    localparam int GAIN_SHIFT = 4;
    localparam int STEP_W   = ACC_W - GAIN_SHIFT;
    localparam int ROOT_W   = 7;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 2;

    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 3;

    localparam int BOOST_SCALE = 25;
    localparam int SEED_NUM    = 15;
    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 14'd12000;

    localparam logic [TARGET_W-1:0] TARGET_RST = 12'd0;
    localparam logic [GAIN_W-1:0]   P_GAIN_RST = 8'd15;
    localparam logic [GAIN_W-1:0]   D_GAIN_RST = 8'd20;
    localparam logic [THR_W-1:0]    THR_RST    = 13'd320;
    localparam logic [DRIVE_W-1:0]  MAX_STEP_RST = 14'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_SPEED    = 3'd0,
        CFG_P_GAIN          = 3'd1,
        CFG_D_GAIN          = 3'd2,
        CFG_BOOST_THRESHOLD = 3'd3,
        CFG_MAX_STEP        = 3'd4
    } cfg_idx_t;

endpackage

// ===== hw/rtl/fvpd_window.sv =====
// sample window shift line with running sum and floor average
// depends on fvpd_pkg
`timescale 1ns / 1ps

module fvpd_window
    import fvpd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic signed [SAMPLE_W-1:0] average
);

    logic signed [SAMPLE_W-1:0] win_reg [WINDOW];
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;

    // oldest sample leaves, newest enters
    assign sum_next = sum_reg
                    - {{WINDOW_LOG2{win_reg[0][SAMPLE_W-1]}}, win_reg[0]}
                    + {{WINDOW_LOG2{sample[SAMPLE_W-1]}}, sample};

    // arithmetic shift gives the floor of sum / WINDOW
    assign average = sum_reg[SUM_W-1:WINDOW_LOG2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (load)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[WINDOW - 1] <= sample;
            sum_reg <= sum_next;
        end
    end

endmodule

// ===== hw/rtl/fvpd_isqrt.sv =====
// bit-serial integer square root, two radicand bits per cycle
// depends on fvpd_pkg
`timescale 1ns / 1ps

module fvpd_isqrt
    import fvpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  rem_diff;
    logic              fits;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // restoring step: bring down two bits, try subtracting 4*root + 1
    assign rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign fits      = (rem_sh >= trial);
    assign rem_diff  = rem_sh - trial;
    assign rem_next  = fits ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    assign root_next = {root_reg[ROOT_W-2:0], fits};

    assign busy = busy_reg;
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != CNT_W'(1));
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

// ===== hw/rtl/fvpd_mac.sv =====
// bit-serial pd product: p_gain*err + d_gain*diff, one gain bit per cycle
// depends on fvpd_pkg
`timescale 1ns / 1ps

module fvpd_mac
    import fvpd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ERR_W-1:0]  err,
    input  logic signed [DIFF_W-1:0] diff,
    input  logic [GAIN_W-1:0]        p_gain,
    input  logic [GAIN_W-1:0]        d_gain,
    output logic                     busy,
    output logic signed [ACC_W-1:0]  acc
);

    localparam int CNT_W = $clog2(GAIN_W + 1);

    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic [GAIN_W-1:0]        p_sr_reg;
    logic [GAIN_W-1:0]        d_sr_reg;
    logic signed [ACC_W-1:0]  err_reg;
    logic signed [ACC_W-1:0]  diff_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // msb-first shift and add over the unsigned gains
    always_comb
    begin
        acc_next = {acc_reg[ACC_W-2:0], 1'b0};
        if (p_sr_reg[GAIN_W-1])
        begin
            acc_next = acc_next + err_reg;
        end
        if (d_sr_reg[GAIN_W-1])
        begin
            acc_next = acc_next + diff_reg;
        end
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(GAIN_W);
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != CNT_W'(1));
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_sr_reg <= p_gain;
            d_sr_reg <= d_gain;
            err_reg  <= {{(ACC_W-ERR_W){err[ERR_W-1]}}, err};
            diff_reg <= {{(ACC_W-DIFF_W){diff[DIFF_W-1]}}, diff};
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            p_sr_reg <= {p_sr_reg[GAIN_W-2:0], 1'b0};
            d_sr_reg <= {d_sr_reg[GAIN_W-2:0], 1'b0};
            acc_reg  <= acc_next;
        end
    end

endmodule

// ===== hw/rtl/flywheel_velocity_pd_drive.sv =====
// flywheel velocity pd drive: top level with config registers, sequencer and drive update
// depends on fvpd_pkg, fvpd_window, fvpd_isqrt, fvpd_mac
`timescale 1ns / 1ps

// Each accepted velocity beat shifts into an eight-sample window, and the block
// returns one result beat: the clamped drive in millivolts, the floor average and
// the speed error. A new beat is taken only once the sequencer is back in idle:
// the window sum and error are registered, the serial units are launched, and the
// bit-serial gain multiply-accumulate runs its eight steps and is seen done
// (the square root for the boost step runs alongside it in seven steps), then the
// step is picked and capped and the drive is updated.
// A finished result waits in the output register while the next beat is taken;
// the drive update stalls only if the previous result has not been taken yet.
// User writes config registers via cfg_we/cfg_index/cfg_data only while idle, unchecked.
module flywheel_velocity_pd_drive
    import fvpd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] velocity_sample,
    input  logic                       restart,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [DRIVE_W-1:0]         drive_mv,
    output logic signed [SAMPLE_W-1:0] mean_velocity,
    output logic signed [ERR_W-1:0]    speed_error
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_START,
        S_RUN,
        S_STEP,
        S_DRIVE
    } state_t;

    state_t state_reg;

    logic [TARGET_W-1:0] target_reg;
    logic [GAIN_W-1:0]   p_gain_reg;
    logic [GAIN_W-1:0]   d_gain_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [DRIVE_W-1:0]  max_step_reg;

    logic [DRIVE_W-1:0]         drive_reg;
    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [SAMPLE_W-1:0] avg_reg;
    logic                       boost_reg;
    logic signed [STEP_W-1:0]   step_reg;
    logic                       out_valid_reg;
    logic [DRIVE_W-1:0]         drive_out_reg;
    logic signed [SAMPLE_W-1:0] avg_out_reg;
    logic signed [ERR_W-1:0]    err_out_reg;

    logic                       accept;
    logic                       unit_start;
    logic                       result_load;
    logic signed [SAMPLE_W-1:0] win_avg;
    logic                       sqrt_busy;
    logic [ROOT_W-1:0]          root;
    logic                       mac_busy;
    logic signed [ACC_W-1:0]    mac_acc;
    logic signed [DIFF_W-1:0]   err_diff;

    logic signed [ERR_W-1:0]    err_next;
    logic                       boost_next;
    logic [DRIVE_W+1:0]         seed_prod;
    logic [DRIVE_W-1:0]         seed_next;
    logic signed [STEP_W-1:0]   boost_step;
    logic signed [STEP_W-1:0]   raw_step;
    logic signed [STEP_W-1:0]   step_next;
    logic signed [STEP_W:0]     drive_sum;
    logic [DRIVE_W-1:0]         drive_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign unit_start  = (state_reg == S_START);
    assign result_load = (state_reg == S_DRIVE) && (!out_valid_reg || out_ready);

    assign out_valid     = out_valid_reg;
    assign drive_mv      = drive_out_reg;
    assign mean_velocity = avg_out_reg;
    assign speed_error   = err_out_reg;

    fvpd_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .sample  (velocity_sample),
        .average (win_avg)
    );

    fvpd_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (unit_start),
        .radicand (RAD_W'(err_reg)),
        .busy     (sqrt_busy),
        .root     (root)
    );

    assign err_diff = {err_reg[ERR_W-1], err_reg} - {prev_err_reg[ERR_W-1], prev_err_reg};

    fvpd_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .err    (err_reg),
        .diff   (err_diff),
        .p_gain (p_gain_reg),
        .d_gain (d_gain_reg),
        .busy   (mac_busy),
        .acc    (mac_acc)
    );

    always_comb
    begin
        err_next   = $signed({{(ERR_W-TARGET_W){1'b0}}, target_reg})
                   - {{(ERR_W-SAMPLE_W){win_avg[SAMPLE_W-1]}}, win_avg};
        boost_next = (err_reg > $signed({{(ERR_W-THR_W){1'b0}}, thr_reg}));

        // restart seed: floor(target * 15 / 2), saturated
        seed_prod = (DRIVE_W+2)'(target_reg * SEED_NUM);
        if (seed_prod[DRIVE_W+1:1] > {1'b0, DRIVE_MAX})
        begin
            seed_next = DRIVE_MAX;
        end
        else
        begin
            seed_next = seed_prod[DRIVE_W:1];
        end

        boost_step = $signed(STEP_W'(root * BOOST_SCALE));
        raw_step   = boost_reg ? boost_step : mac_acc[ACC_W-1:GAIN_SHIFT];
        if (raw_step > $signed({{(STEP_W-DRIVE_W){1'b0}}, max_step_reg}))
        begin
            step_next = $signed({{(STEP_W-DRIVE_W){1'b0}}, max_step_reg});
        end
        else
        begin
            step_next = raw_step;
        end

        drive_sum = $signed({{(STEP_W+1-DRIVE_W){1'b0}}, drive_reg})
                  + {step_reg[STEP_W-1], step_reg};
        if (drive_sum[STEP_W])
        begin
            drive_next = '0;
        end
        else if (drive_sum > $signed({{(STEP_W+1-DRIVE_W){1'b0}}, DRIVE_MAX}))
        begin
            drive_next = DRIVE_MAX;
        end
        else
        begin
            drive_next = drive_sum[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_RST;
            p_gain_reg   <= P_GAIN_RST;
            d_gain_reg   <= D_GAIN_RST;
            thr_reg      <= THR_RST;
            max_step_reg <= MAX_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_SPEED:    target_reg   <= cfg_data[TARGET_W-1:0];
                CFG_P_GAIN:          p_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_D_GAIN:          d_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_BOOST_THRESHOLD: thr_reg      <= cfg_data[THR_W-1:0];
                CFG_MAX_STEP:        max_step_reg <= cfg_data[DRIVE_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
            prev_err_reg  <= '0;
            err_reg       <= '0;
            avg_reg       <= '0;
            boost_reg     <= 1'b0;
            step_reg      <= '0;
            drive_out_reg <= '0;
            avg_out_reg   <= '0;
            err_out_reg   <= '0;
        end
        else
        begin
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (restart)
                        begin
                            drive_reg    <= seed_next;
                            prev_err_reg <= $signed({{(ERR_W-TARGET_W){1'b0}}, target_reg});
                        end
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    err_reg   <= err_next;
                    avg_reg   <= win_avg;
                    state_reg <= S_START;
                end
                S_START:
                begin
                    boost_reg <= boost_next;
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (!sqrt_busy && !mac_busy)
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    step_reg  <= step_next;
                    state_reg <= S_DRIVE;
                end
                S_DRIVE:
                begin
                    // hold here while the previous beat is still unclaimed
                    if (result_load)
                    begin
                        drive_reg     <= drive_next;
                        prev_err_reg  <= err_reg;
                        drive_out_reg <= drive_next;
                        avg_out_reg   <= avg_reg;
                        err_out_reg   <= err_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_mv <= DRIVE_MAX))
        else $error("drive beat above the clamp");

    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!sqrt_busy && !mac_busy))
        else $error("serial unit busy while taking a new beat");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DRIVE))
        else $error("result beat raised outside the drive update");

    a_error_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (speed_error == ($signed({{(ERR_W-TARGET_W){1'b0}}, target_reg})
            - {{(ERR_W-SAMPLE_W){mean_velocity[SAMPLE_W-1]}}, mean_velocity})))
        else $error("speed error does not match target minus average");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (!in_ready && (state_reg == S_ERR)))
        else $error("sequencer did not start on an accepted beat");

endmodule
